/* hw/rtl/btps_pkg.sv */
// Shared constants, codes and types of the bit tree predecessor/successor block.
package btps_pkg;

    localparam int MAX_LEAVES   = 4096;
    localparam int RESET_LEAVES = 4096;
    localparam int POS_W        = $clog2(MAX_LEAVES);
    localparam int CNT_W        = $clog2(MAX_LEAVES + 1);
    localparam int NODE_DEPTH   = 2 * MAX_LEAVES - 1;
    localparam int NODE_W       = $clog2(NODE_DEPTH);
    localparam int CMD_W        = 2;
    localparam int IN_W         = ((CMD_W + POS_W + 7) / 8) * 8;
    localparam int OUT_W        = ((POS_W + 2 + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK = 2'd0,
        CMD_PREV = 2'd1,
        CMD_NEXT = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_INIT_A,
        ST_INIT_B,
        ST_IDLE,
        ST_FIRST,
        ST_MARK,
        ST_CLIMB,
        ST_DESC,
        ST_CONV,
        ST_DONE
    } state_t;

    // Tree geometry derived from the leaf count.
    typedef struct packed {
        logic [CNT_W-1:0]  leaf_count;
        logic [NODE_W-1:0] leaf_last;   // leaf_count - 1, also the first leaf node
        logic [NODE_W-1:0] node_total;
        logic [NODE_W-1:0] bot_first;   // first node of the bottom level
        logic [NODE_W-1:0] lower_cnt;   // leaves on the bottom level
        logic [NODE_W-1:0] upper_cnt;   // leaves on the level above
    } geom_t;

    typedef struct packed {
        logic [POS_W-1:0] found_pos;
        logic             leaf_bit;
        logic             status;
    } res_t;

endpackage

/* hw/rtl/btps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module btps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/btps_geom.sv */
// Leaf count register and the tree geometry derived from it.
module btps_geom
    import btps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [CNT_W-1:0] wr_data,
    output geom_t            geom
);

    function automatic geom_t geom_of(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0]  l;
        logic [NODE_W:0]   twice;
        logic [NODE_W-1:0] nt;
        logic [NODE_W-1:0] thr;
        logic [NODE_W-1:0] full;
        logic [NODE_W-1:0] low;
        geom_t             g;
        l = count;
        if (count == '0)
        begin
            l = CNT_W'(1);
        end
        else if (count > CNT_W'(MAX_LEAVES))
        begin
            l = CNT_W'(MAX_LEAVES);
        end
        twice = {1'b0, NODE_W'(l)} + {1'b0, NODE_W'(l)} - (NODE_W + 1)'(1);
        nt    = twice[NODE_W-1:0];
        // thr ends up as the all-ones mask below the top set bit of nt
        thr = '0;
        for (int i = 1; i < NODE_W; i++)
        begin
            if (nt[i])
            begin
                thr = (NODE_W'(1) << i) - NODE_W'(1);
            end
        end
        full = {thr[NODE_W-2:0], 1'b1};
        low  = (nt == full) ? '0 : nt - thr;
        g.leaf_count = l;
        g.leaf_last  = NODE_W'(l) - NODE_W'(1);
        g.node_total = nt;
        g.bot_first  = thr;
        g.lower_cnt  = low;
        g.upper_cnt  = NODE_W'(l) - low;
        return g;
    endfunction

    geom_t geom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= geom_of(CNT_W'(RESET_LEAVES));
        end
        else if (wr_en)
        begin
            geom_reg <= geom_of(wr_data);
        end
    end

    assign geom = geom_reg;

endmodule

/* hw/rtl/btps_seq.sv */
// Command sequencer: clears and seeds the mark tree, marks leaves, walks searches.
module btps_seq
    import btps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic             restart,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [CMD_W-1:0] req_cmd,
    input  logic [POS_W-1:0] req_pos,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res
);

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NODE_W-1:0] n_reg, n_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic [POS_W-1:0]  found_reg, found_next;
    logic              bit_reg, bit_next;
    logic              err_reg, err_next;
    logic              init_reg, init_next;
    logic              init_b_reg, init_b_next;
    logic              ok_reg, ok_next;

    logic              we;
    logic [NODE_W-1:0] waddr;
    logic              wdata;
    logic [NODE_W-1:0] rd_node;
    logic [NODE_W-1:0] raddr;
    logic              rdata;
    logic              rbit;

    logic              fwd;
    logic [NODE_W-1:0] par;
    logic [NODE_W-1:0] side;
    logic [NODE_W-1:0] child_l;
    logic [NODE_W-1:0] child_r;
    logic [NODE_W-1:0] pick;
    logic [NODE_W-1:0] desc_from;
    logic [NODE_W:0]   pos_inc;
    logic              pos_in;
    logic              do_mark;
    logic              do_climb;
    logic              do_desc;
    logic              q_err;

    function automatic logic [NODE_W-1:0] to_node(input geom_t g, input logic [POS_W-1:0] p);
        logic [NODE_W-1:0] pe;
        pe = NODE_W'(p);
        return (pe >= g.lower_cnt) ? g.leaf_last + pe - g.lower_cnt : g.bot_first + pe;
    endfunction

    function automatic logic [POS_W-1:0] to_leaf(input geom_t g, input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] v;
        v = (n >= g.bot_first) ? n - g.bot_first : n - g.leaf_last + g.lower_cnt;
        return v[POS_W-1:0];
    endfunction

    // Child probed on the way down: left for next, right for previous.
    function automatic logic [NODE_W-1:0] probe(input logic [NODE_W-1:0] m, input logic f);
        logic [NODE_W-1:0] l;
        l = {m[NODE_W-2:0], 1'b1};
        return f ? l : l + NODE_W'(1);
    endfunction

    btps_ram #(
        .WIDTH (1),
        .DEPTH (NODE_DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rbit    = rdata & ok_reg;
    assign fwd     = (cmd_reg == CMD_NEXT);
    assign par     = (n_reg - NODE_W'(1)) >> 1;
    assign child_l = {n_reg[NODE_W-2:0], 1'b1};
    assign child_r = child_l + NODE_W'(1);
    assign pick    = fwd ? (rbit ? child_l : child_r) : (rbit ? child_r : child_l);
    assign pos_inc = (NODE_W + 1)'(pos_reg) + (NODE_W + 1)'(1);
    assign pos_in  = (CNT_W'(pos_reg) < geom.leaf_count);
    assign q_err   = (pos_reg == '0) || (pos_inc >= (NODE_W + 1)'(geom.leaf_count));

    always_comb
    begin
        if (fwd)
        begin
            side = n_reg[0] ? par : n_reg + NODE_W'(1);
        end
        else
        begin
            side = n_reg[0] ? n_reg - NODE_W'(1) : par;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        clr_next    = clr_reg;
        found_next  = found_reg;
        bit_next    = bit_reg;
        err_next    = err_reg;
        init_next   = init_reg;
        init_b_next = init_b_reg;
        we          = 1'b0;
        waddr       = n_reg;
        wdata       = 1'b1;
        rd_node     = n_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        do_mark     = 1'b0;
        do_climb    = 1'b0;
        do_desc     = 1'b0;
        desc_from   = n_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = 1'b0;
                if (clr_reg == geom.node_total - NODE_W'(1))
                begin
                    state_next = ST_INIT_A;
                end
                else
                begin
                    clr_next = clr_reg + NODE_W'(1);
                end
            end
            ST_INIT_A:
            begin
                rd_node     = to_node(geom, '0);
                n_next      = rd_node;
                init_next   = 1'b1;
                init_b_next = 1'b0;
                state_next  = ST_MARK;
            end
            ST_INIT_B:
            begin
                rd_node     = to_node(geom, geom.leaf_last[POS_W-1:0]);
                n_next      = rd_node;
                init_b_next = 1'b1;
                state_next  = ST_MARK;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next   = req_cmd;
                    pos_next   = req_pos;
                    rd_node    = to_node(geom, req_pos);
                    n_next     = rd_node;
                    init_next  = 1'b0;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                bit_next   = pos_in & rbit;
                found_next = pos_reg;
                if (cmd_reg == CMD_MARK)
                begin
                    err_next = !pos_in;
                    do_mark  = pos_in;
                end
                else if (cmd_reg == CMD_PREV || cmd_reg == CMD_NEXT)
                begin
                    err_next = q_err;
                    do_climb = !q_err;
                end
                else
                begin
                    err_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_MARK:
            begin
                do_mark = 1'b1;
            end
            ST_CLIMB:
            begin
                do_climb = 1'b1;
            end
            ST_DESC:
            begin
                do_desc   = 1'b1;
                desc_from = pick;
            end
            ST_CONV:
            begin
                found_next = (n_reg < geom.node_total) ? to_leaf(geom, n_reg) : pos_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Mark: set the node and climb until a set node or the root.
        if (do_mark)
        begin
            if (rbit || !ok_reg || n_reg == '0)
            begin
                if (!rbit && ok_reg)
                begin
                    we = 1'b1;
                end
                if (!init_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = init_b_reg ? ST_IDLE : ST_INIT_B;
                end
            end
            else
            begin
                we         = 1'b1;
                n_next     = par;
                rd_node    = par;
                state_next = ST_MARK;
            end
        end

        // Climb: sidestep or go up until a set node, then head down.
        if (do_climb)
        begin
            if (!rbit && n_reg != '0)
            begin
                n_next     = side;
                rd_node    = side;
                state_next = ST_CLIMB;
            end
            else
            begin
                do_desc = 1'b1;
            end
        end

        if (do_desc)
        begin
            n_next = desc_from;
            if (desc_from < geom.leaf_last)
            begin
                rd_node    = probe(desc_from, fwd);
                state_next = ST_DESC;
            end
            else
            begin
                state_next = ST_CONV;
            end
        end

        if (restart)
        begin
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    assign ok_next = (rd_node < geom.node_total);
    assign raddr   = ok_next ? rd_node : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            init_reg   <= 1'b0;
            init_b_reg <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            init_reg   <= init_next;
            init_b_reg <= init_b_next;
            ok_reg     <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pos_reg   <= pos_next;
        n_reg     <= n_next;
        found_reg <= found_next;
        bit_reg   <= bit_next;
        err_reg   <= err_next;
    end

    assign res.found_pos = found_reg;
    assign res.leaf_bit  = bit_reg;
    assign res.status    = err_reg;

endmodule

/* hw/rtl/bit_tree_predecessor_successor.sv */
// Bit tree predecessor/successor block: stream ports, output register, instances.
//
// Keeps one mark bit per node of a heap-ordered binary tree over leaf_count leaves
// and answers mark, previous-marked and next-marked requests one at a time. All
// marks live in a single one-bit-wide RAM with registered read data. A mark sets
// nodes from the leaf upward until it meets a set node or the root. A search's
// climb may sidestep and step up once per level before it descends to the found
// leaf. After reset and after every leaf_count write the block clears the tree,
// one node per cycle, over all 2 * leaf_count - 1 nodes, then seeds the first and
// last leaf; no request is taken during that time. A finished result sits in the
// output register while the next request is already being worked on.
module bit_tree_predecessor_successor
    import btps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd [1:0], pos [13:2], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // found_pos [11:0], leaf_bit [12], status [13], zero pad
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data   // leaf_count
);

    geom_t geom;
    logic  res_valid;
    logic  res_ready;
    res_t  res;
    res_t  out_reg;
    logic  m_tvalid_reg, m_tvalid_next;

    assign cfg_ready = 1'b1;

    btps_geom u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid),
        .wr_data (cfg_data),
        .geom    (geom)
    );

    btps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .restart   (cfg_valid),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_cmd   (s_tdata[CMD_W-1:0]),
        .req_pos   (s_tdata[CMD_W+POS_W-1:CMD_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result when the output register is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_W - POS_W - 2)'(0), out_reg.status, out_reg.leaf_bit,
                       out_reg.found_pos};

endmodule
